>>> rtl/swd_pkg.sv
// Shared types and constants for the four-lane swinging-door compressor.
// Holds the payload structs, register map and reset values; no dependencies.
`timescale 1ns / 1ps

package swd_pkg;

  localparam int SampleWidthDef = 16;
  localparam int LaneCountDef   = 4;
  localparam int FieldLanes     = 4;
  localparam int DevWidth       = 15;
  localparam int LightDevWidth  = 7;
  localparam int HeldWidth      = 15;
  localparam int HeldLightWidth = 7;
  localparam int RegAddrWidth   = 4;
  localparam int LightShift     = 12;
  localparam int LightProdWidth = 23;

  localparam int LaneTemp  = 0;
  localparam int LaneHum   = 1;
  localparam int LaneDist  = 2;
  localparam int LaneLight = 3;

  typedef enum logic [1:0] {
    REG_TEMP_DEV  = 2'd0,
    REG_HUM_DEV   = 2'd1,
    REG_DIST_DEV  = 2'd2,
    REG_LIGHT_DEV = 2'd3
  } reg_index_t;

  localparam logic [DevWidth-1:0]      TempDevRst  = 15'd40;
  localparam logic [DevWidth-1:0]      HumDevRst   = 15'd100;
  localparam logic [DevWidth-1:0]      DistDevRst  = 15'd10;
  localparam logic [LightDevWidth-1:0] LightDevRst = 7'd5;

  localparam logic [6:0] Hundred   = 7'd100;
  localparam logic [6:0] LightFull = 7'd100;

  typedef struct packed {
    logic [7:0]  temp_whole;
    logic [7:0]  temp_fraction;
    logic [7:0]  hum_whole;
    logic [7:0]  hum_fraction;
    logic [14:0] distance_cm;
    logic [15:0] light_raw;
  } sample_t;

  typedef struct packed {
    logic [HeldWidth-1:0]      held_temp;
    logic [HeldWidth-1:0]      held_hum;
    logic [HeldWidth-1:0]      held_dist;
    logic [HeldLightWidth-1:0] held_light;
    logic                      temp_changed;
    logic                      hum_changed;
    logic                      dist_changed;
    logic                      light_changed;
  } result_t;

endpackage

>>> rtl/swd_front.sv
// Front stage: rebuilds the four lane samples from the raw sensor fields and registers them.
// Depends on swd_pkg.
`timescale 1ns / 1ps

module swd_front import swd_pkg::*; #(
  parameter int SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                                    clk,
  input  logic                                    load,
  input  sample_t                                 sample,
  output logic [FieldLanes-1:0][SAMPLE_WIDTH-1:0] lane_sample
);

  logic [14:0]               temp_val;
  logic [14:0]               hum_val;
  logic [LightProdWidth-1:0] light_prod;
  logic [LightProdWidth-LightShift-1:0] light_pct;
  logic [6:0]                light_sat;
  logic [FieldLanes-1:0][31:0] wide;

  always_comb begin
    temp_val   = 15'(sample.temp_whole) * 15'(Hundred) + 15'(sample.temp_fraction);
    hum_val    = 15'(sample.hum_whole) * 15'(Hundred) + 15'(sample.hum_fraction);
    light_prod = LightProdWidth'(sample.light_raw) * LightProdWidth'(Hundred);
    light_pct  = light_prod[LightProdWidth-1:LightShift];
    // saturate at full scale
    light_sat  = (light_pct > (LightProdWidth-LightShift)'(LightFull)) ? LightFull
                                                                       : light_pct[6:0];
    wide[LaneTemp]  = 32'(temp_val);
    wide[LaneHum]   = 32'(hum_val);
    wide[LaneDist]  = 32'(sample.distance_cm);
    wide[LaneLight] = 32'(light_sat);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < FieldLanes; k++) begin
        lane_sample[k] <= wide[k][SAMPLE_WIDTH-1:0];
      end
    end
  end

endmodule

>>> rtl/swd_lane.sv
// One swinging-door lane: stored and previous sample, upper and lower door.
// Depends on swd_pkg.
`timescale 1ns / 1ps

module swd_lane import swd_pkg::*; #(
  parameter int SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    update,
  input  logic                    first,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic [DevWidth-1:0]     dev,
  output logic [SAMPLE_WIDTH-1:0] held_next,
  output logic                    changed
);

  localparam int MaxW = (SAMPLE_WIDTH > DevWidth) ? SAMPLE_WIDTH : DevWidth;
  localparam int CW   = MaxW + 2;
  localparam int DW   = SAMPLE_WIDTH + 2;
  localparam logic signed [CW-1:0] ClampHi = {{(CW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [CW-1:0] ClampLo = ~ClampHi;
  localparam logic signed [DW-1:0] DoorMin = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] DoorMax = ~DoorMin;

  function automatic logic signed [DW-1:0] clamp(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] c;
    c = v;
    if (v > ClampHi) c = ClampHi;
    if (v < ClampLo) c = ClampLo;
    return signed'(c[DW-1:0]);
  endfunction

  logic [SAMPLE_WIDTH-1:0] stored;
  logic [SAMPLE_WIDTH-1:0] previous;
  logic signed [DW-1:0]    upper;
  logic signed [DW-1:0]    lower;

  logic [SAMPLE_WIDTH-1:0] stored_eff;
  logic [SAMPLE_WIDTH-1:0] previous_eff;
  logic signed [CW-1:0]    s_x;
  logic signed [CW-1:0]    d_x;
  logic signed [CW-1:0]    st_x;
  logic signed [CW-1:0]    pv_x;
  logic signed [DW-1:0]    a_up;
  logic signed [DW-1:0]    a_dn;
  logic signed [DW-1:0]    b_up;
  logic signed [DW-1:0]    b_dn;
  logic signed [DW-1:0]    up_max;
  logic signed [DW-1:0]    dn_min;
  logic                    doors_cross;
  logic signed [DW-1:0]    upper_next;
  logic signed [DW-1:0]    lower_next;

  always_comb begin
    // the first sample seeds both stored and previous
    stored_eff   = first ? sample : stored;
    previous_eff = first ? sample : previous;
    s_x  = signed'({{(CW-SAMPLE_WIDTH){1'b0}}, sample});
    st_x = signed'({{(CW-SAMPLE_WIDTH){1'b0}}, stored_eff});
    pv_x = signed'({{(CW-SAMPLE_WIDTH){1'b0}}, previous_eff});
    d_x  = signed'({{(CW-DevWidth){1'b0}}, dev});
    // doors against the current stored value and, for a restart, the previous sample
    a_up = clamp(s_x - st_x - d_x);
    a_dn = clamp(s_x - st_x + d_x);
    b_up = clamp(s_x - pv_x - d_x);
    b_dn = clamp(s_x - pv_x + d_x);
    up_max = (a_up > upper) ? a_up : upper;
    dn_min = (a_dn < lower) ? a_dn : lower;
    doors_cross = (up_max >= dn_min);
    held_next  = doors_cross ? previous_eff : stored_eff;
    upper_next = doors_cross ? b_up : up_max;
    lower_next = doors_cross ? b_dn : dn_min;
    changed    = first || (held_next != stored);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored   <= '0;
      previous <= '0;
      upper    <= DoorMin;
      lower    <= DoorMax;
    end else if (update) begin
      stored   <= held_next;
      previous <= sample;
      upper    <= upper_next;
      lower    <= lower_next;
    end
  end

endmodule

>>> rtl/four_lane_swinging_door_compressor.sv
// Four-lane swinging-door compressor, top level: config registers, handshake and lane merge.
// Depends on swd_pkg, swd_front and swd_lane.
`timescale 1ns / 1ps

// Usage
//   sample channel: sample_valid / sample_stall / sample carry one sensor set per transfer.
//   result channel: result_valid / result_stall / result carry one result per sample,
//   in order: held value and change flag for temperature, humidity, distance and light.
//   APB port: four deviation registers at byte addresses 0, 4, 8 and 12; write only
//   while the block is idle. pready is tied high.
// Path: a transferred sample passes the front register, then the result register, which
// loads when the result side is free.
// Throughput: one sample per cycle while the result side does not stall; every instantiated
// lane updates in parallel against its own state.
// Reset (rst, synchronous): empties both stages, clears the lane state, marks the next
// sample as the first one and loads the deviation registers with their defaults.
// Receiver stall: the result register holds; an empty front register still takes one more
// sample, then sample_stall rises until the result is taken.

module four_lane_swinging_door_compressor import swd_pkg::*; #(
  parameter int SAMPLE_WIDTH = SampleWidthDef,
  parameter int LANE_COUNT   = LaneCountDef
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [RegAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  sample_t                 sample,
  output logic                    result_valid,
  input  logic                    result_stall,
  output result_t                 result
);

  localparam int ActiveLanes = (LANE_COUNT < FieldLanes) ? LANE_COUNT : FieldLanes;

  logic [DevWidth-1:0]      temp_dev;
  logic [DevWidth-1:0]      hum_dev;
  logic [DevWidth-1:0]      dist_dev;
  logic [LightDevWidth-1:0] light_dev;

  logic       cfg_write;
  reg_index_t cfg_index;

  logic s1_valid;
  logic first_pending;
  logic out_free;
  logic s1_free;
  logic advance;

  logic [FieldLanes-1:0][SAMPLE_WIDTH-1:0] lane_sample;
  logic [FieldLanes-1:0][DevWidth-1:0]     lane_dev;
  logic [FieldLanes-1:0][SAMPLE_WIDTH-1:0] lane_held;
  logic [FieldLanes-1:0]                   lane_changed;
  logic [FieldLanes-1:0][31:0]             held_wide;
  result_t                                 result_next;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[RegAddrWidth-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_dev  <= TempDevRst;
      hum_dev   <= HumDevRst;
      dist_dev  <= DistDevRst;
      light_dev <= LightDevRst;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEMP_DEV:  temp_dev  <= pwdata[DevWidth-1:0];
        REG_HUM_DEV:   hum_dev   <= pwdata[DevWidth-1:0];
        REG_DIST_DEV:  dist_dev  <= pwdata[DevWidth-1:0];
        REG_LIGHT_DEV: light_dev <= pwdata[LightDevWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_TEMP_DEV:  prdata = 32'(temp_dev);
      REG_HUM_DEV:   prdata = 32'(hum_dev);
      REG_DIST_DEV:  prdata = 32'(dist_dev);
      REG_LIGHT_DEV: prdata = 32'(light_dev);
      default:       prdata = '0;
    endcase
  end

  // pipeline control: front register, then result register
  assign out_free     = !result_valid || !result_stall;
  assign s1_free      = !s1_valid || out_free;
  assign sample_stall = !s1_free;
  assign advance      = s1_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      result_valid  <= 1'b0;
      first_pending <= 1'b1;
    end else begin
      if (s1_free) s1_valid <= sample_valid;
      if (out_free) result_valid <= s1_valid;
      if (advance) first_pending <= 1'b0;
    end
  end

  swd_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .load       (sample_valid && !sample_stall),
    .sample     (sample),
    .lane_sample(lane_sample)
  );

  assign lane_dev[LaneTemp]  = temp_dev;
  assign lane_dev[LaneHum]   = hum_dev;
  assign lane_dev[LaneDist]  = dist_dev;
  assign lane_dev[LaneLight] = DevWidth'(light_dev);

  for (genvar k = 0; k < FieldLanes; k++) begin : g_lane
    if (k < ActiveLanes) begin : g_on
      swd_lane #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_lane (
        .clk      (clk),
        .rst      (rst),
        .update   (advance),
        .first    (first_pending),
        .sample   (lane_sample[k]),
        .dev      (lane_dev[k]),
        .held_next(lane_held[k]),
        .changed  (lane_changed[k])
      );
    end else begin : g_off
      assign lane_held[k]    = '0;
      assign lane_changed[k] = 1'b0;
    end
    assign held_wide[k] = 32'(lane_held[k]);
  end

  // merge the lanes into one result
  always_comb begin
    result_next.held_temp     = held_wide[LaneTemp][HeldWidth-1:0];
    result_next.held_hum      = held_wide[LaneHum][HeldWidth-1:0];
    result_next.held_dist     = held_wide[LaneDist][HeldWidth-1:0];
    result_next.held_light    = held_wide[LaneLight][HeldLightWidth-1:0];
    result_next.temp_changed  = lane_changed[LaneTemp];
    result_next.hum_changed   = lane_changed[LaneHum];
    result_next.dist_changed  = lane_changed[LaneDist];
    result_next.light_changed = lane_changed[LaneLight];
  end

  always_ff @(posedge clk) begin
    if (advance) result <= result_next;
  end

endmodule

>>> rtl/swd_checker.sv
// Port-level checks for the four-lane swinging-door compressor, bound to the top level.
// Depends on swd_pkg and four_lane_swinging_door_compressor.
`timescale 1ns / 1ps

module swd_checker import swd_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  logic    seen;
  result_t last_result;
  logic    take;

  assign take = result_valid && !result_stall;

  // remember the last transferred result
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (take) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) last_result <= result;
  end

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result_valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |-> result_valid && result_stall)
    else $error("sample input stalled while the result side was free");

  a_unchanged_lane: assert property (@(posedge clk) disable iff (rst)
    seen && take |->
      (result.temp_changed  || result.held_temp  == last_result.held_temp)  &&
      (result.hum_changed   || result.held_hum   == last_result.held_hum)   &&
      (result.dist_changed  || result.held_dist  == last_result.held_dist)  &&
      (result.light_changed || result.held_light == last_result.held_light))
    else $error("held value moved without its change flag");

  a_light_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.held_light <= LightFull)
    else $error("held light above full scale");

endmodule

bind four_lane_swinging_door_compressor swd_checker u_swd_checker (
  .clk         (clk),
  .rst         (rst),
  .sample_valid(sample_valid),
  .sample_stall(sample_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

>>> tb/sv/swd_result_checker.sv
// Result checker for the four-lane swinging-door compressor: watches both channels and APB,
// keeps its own copy of the lane state and deviations, and counts mismatches.
// Depends on swd_pkg.
`timescale 1ns / 1ps

module swd_result_checker import swd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [RegAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  input  logic [31:0]             prdata,
  input  logic                    pready,
  input  logic                    sample_valid,
  input  logic                    sample_stall,
  input  sample_t                 sample,
  input  logic                    result_valid,
  input  logic                    result_stall,
  input  result_t                 result,
  output int                      mismatches,
  output int                      outstanding
);

  localparam int DoorMax = 2 ** (SampleWidthDef + 1) - 1;
  localparam int DoorMin = -DoorMax - 1;

  int      deviation  [FieldLanes];
  int      held_level [FieldLanes];
  int      last_level [FieldLanes];
  int      upper_door [FieldLanes];
  int      lower_door [FieldLanes];
  logic    awaiting_first;
  result_t expected_held [$];

  function automatic int door_bound(int v);
    if (v > DoorMax) return DoorMax;
    if (v < DoorMin) return DoorMin;
    return v;
  endfunction

  function automatic int lane_of(reg_index_t idx);
    case (idx)
      REG_TEMP_DEV: return LaneTemp;
      REG_HUM_DEV:  return LaneHum;
      REG_DIST_DEV: return LaneDist;
      default:      return LaneLight;
    endcase
  endfunction

  // Advance every lane's door pair by one sample set and return the held values.
  function automatic result_t compress_sample(sample_t s);
    int                    level [FieldLanes];
    int                    light;
    int                    up;
    int                    dn;
    int                    held_was;
    int                    k;
    logic [FieldLanes-1:0] moved;
    result_t               r;
    level[LaneTemp]  = int'(s.temp_whole) * int'(Hundred) + int'(s.temp_fraction);
    level[LaneHum]   = int'(s.hum_whole) * int'(Hundred) + int'(s.hum_fraction);
    level[LaneDist]  = int'(s.distance_cm);
    light            = (int'(s.light_raw) * int'(Hundred)) >>> LightShift;
    level[LaneLight] = (light > int'(LightFull)) ? int'(LightFull) : light;
    for (k = 0; k < FieldLanes; k++) begin
      if (awaiting_first) begin
        held_level[k] = level[k];
        last_level[k] = level[k];
      end
      held_was = held_level[k];
      up = door_bound(level[k] - held_level[k] - deviation[k]);
      dn = door_bound(level[k] - held_level[k] + deviation[k]);
      if (up > upper_door[k]) upper_door[k] = up;
      if (dn < lower_door[k]) lower_door[k] = dn;
      // doors crossed: re-anchor on the previous sample and reopen both doors
      if (upper_door[k] >= lower_door[k]) begin
        held_level[k] = last_level[k];
        upper_door[k] = door_bound(level[k] - held_level[k] - deviation[k]);
        lower_door[k] = door_bound(level[k] - held_level[k] + deviation[k]);
      end
      last_level[k] = level[k];
      moved[k] = awaiting_first || (held_level[k] != held_was);
    end
    awaiting_first = 1'b0;
    r.held_temp     = HeldWidth'(held_level[LaneTemp]);
    r.held_hum      = HeldWidth'(held_level[LaneHum]);
    r.held_dist     = HeldWidth'(held_level[LaneDist]);
    r.held_light    = HeldLightWidth'(held_level[LaneLight]);
    r.temp_changed  = moved[LaneTemp];
    r.hum_changed   = moved[LaneHum];
    r.dist_changed  = moved[LaneDist];
    r.light_changed = moved[LaneLight];
    return r;
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t checker: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      lane;
    if (rst) begin
      deviation[LaneTemp]  = int'(TempDevRst);
      deviation[LaneHum]   = int'(HumDevRst);
      deviation[LaneDist]  = int'(DistDevRst);
      deviation[LaneLight] = int'(LightDevRst);
      for (int k = 0; k < FieldLanes; k++) begin
        held_level[k] = 0;
        last_level[k] = 0;
        upper_door[k] = DoorMin;
        lower_door[k] = DoorMax;
      end
      awaiting_first = 1'b1;
      expected_held.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pready) begin
        lane = lane_of(reg_index_t'(paddr[RegAddrWidth-1:2]));
        if (pwrite) begin
          deviation[lane] = (lane == LaneLight) ? int'(pwdata[LightDevWidth-1:0])
                                                : int'(pwdata[DevWidth-1:0]);
        end else begin
          compare_field("prdata", deviation[lane], int'(prdata));
        end
      end
      if (result_valid && !result_stall) begin
        if (expected_held.size() == 0) begin
          mismatches++;
          $display("%0t checker: unexpected result expected none got %h", $time, result);
        end else begin
          want = expected_held.pop_front();
          compare_field("held_temp", int'(want.held_temp), int'(result.held_temp));
          compare_field("held_hum", int'(want.held_hum), int'(result.held_hum));
          compare_field("held_dist", int'(want.held_dist), int'(result.held_dist));
          compare_field("held_light", int'(want.held_light), int'(result.held_light));
          compare_field("temp_changed", int'(want.temp_changed), int'(result.temp_changed));
          compare_field("hum_changed", int'(want.hum_changed), int'(result.hum_changed));
          compare_field("dist_changed", int'(want.dist_changed), int'(result.dist_changed));
          compare_field("light_changed", int'(want.light_changed),
                        int'(result.light_changed));
        end
      end
      if (sample_valid && !sample_stall) expected_held.push_back(compress_sample(sample));
    end
    outstanding <= expected_held.size();
  end

endmodule

>>> tb/sv/tb.sv
// Top of the compressor testbench: clock, reset, APB programming, sample stimulus and
// result back-pressure. Depends on swd_pkg, the compressor and swd_result_checker.
`timescale 1ns / 1ps

module tb;
  import swd_pkg::*;

  localparam int PressureCycles = 200;
  localparam int ItemsPerPhase  = 150;
  localparam int PhaseCount     = 6;
  localparam int DrainCycles    = 6;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [RegAddrWidth-1:0] paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    sample_valid;
  logic                    sample_stall;
  sample_t                 sample;
  logic                    result_valid;
  logic                    result_stall;
  result_t                 result;
  int                      mismatches;
  int                      outstanding;

  logic gappy;
  logic pressure_req;
  logic pressure_done;
  int   temp_lvl;
  int   hum_lvl;
  int   dist_lvl;
  int   light_lvl;

  always #1 clk = ~clk;

  four_lane_swinging_door_compressor dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  swd_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  function automatic int bound(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int wobble(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic sample_t make_sample(int tw, int tf, int hw, int hf, int d, int l);
    sample_t s;
    s.temp_whole    = 8'(tw);
    s.temp_fraction = 8'(tf);
    s.hum_whole     = 8'(hw);
    s.hum_fraction  = 8'(hf);
    s.distance_cm   = 15'(d);
    s.light_raw     = 16'(l);
    return s;
  endfunction

  // Mostly slow trends with flat stretches and the odd jump; a few raw sensor bytes.
  function automatic sample_t drift_sample(int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return make_sample($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 32767), $urandom_range(0, 65535));
    end
    if (r < 14) begin
      temp_lvl  = $urandom_range(0, 25599);
      hum_lvl   = $urandom_range(0, 25599);
      dist_lvl  = $urandom_range(0, 32767);
      light_lvl = $urandom_range(0, 65535);
    end else if (r >= 35) begin
      temp_lvl  = bound(temp_lvl + wobble(span), 0, 25599);
      hum_lvl   = bound(hum_lvl + wobble(span), 0, 25599);
      dist_lvl  = bound(dist_lvl + wobble(span), 0, 32767);
      light_lvl = bound(light_lvl + 16 * wobble(span), 0, 4400);
    end
    return make_sample(temp_lvl / 100, temp_lvl % 100, hum_lvl / 100, hum_lvl % 100,
                       dist_lvl, light_lvl);
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gappy || (pressure_req && !pressure_done) || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [31:0] pick_deviation(int top);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, (top < 200) ? top : 200);
    if (r < 80) return $urandom_range(0, (top < 2000) ? top : 2000);
    return $urandom_range(0, top);
  endfunction

  // Enter at a falling edge; return at the falling edge after the transfer.
  task automatic send_sample(input sample_t s);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Setup then access phase; psel is left high so accesses can run back to back.
  task automatic apb_access(input reg_index_t idx, input logic is_write,
                            input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic read_deviations();
    apb_access(REG_TEMP_DEV, 1'b0, '0);
    apb_access(REG_HUM_DEV, 1'b0, '0);
    apb_access(REG_DIST_DEV, 1'b0, '0);
    apb_access(REG_LIGHT_DEV, 1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_deviations(input logic [31:0] t, input logic [31:0] h,
                                    input logic [31:0] d, input logic [31:0] l);
    apb_access(REG_TEMP_DEV, 1'b1, t);
    apb_access(REG_HUM_DEV, 1'b1, h);
    apb_access(REG_DIST_DEV, 1'b1, d);
    apb_access(REG_LIGHT_DEV, 1'b1, l);
    read_deviations();
  endtask

  // Drop valid, wait for every result to arrive, then let the pipeline settle.
  task automatic settle();
    sample_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  initial begin
    int p;
    int i;
    int span;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sample_valid = 1'b0;
    sample       = '0;
    gappy        = 1'b1;
    pressure_req = 1'b0;
    temp_lvl     = 2200;
    hum_lvl      = 4500;
    dist_lvl     = 300;
    light_lvl    = 2000;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    read_deviations();

    // first sample seeds every lane, then holds, drift, crossings and field extremes
    send_sample(make_sample(20, 50, 45, 30, 100, 2048));
    send_sample(make_sample(20, 50, 45, 30, 100, 2048));
    send_sample(make_sample(20, 55, 45, 30, 101, 2060));
    send_sample(make_sample(25, 0, 60, 0, 500, 4096));
    send_sample(make_sample(0, 0, 0, 0, 0, 0));
    send_sample(make_sample(255, 255, 255, 255, 32767, 65535));
    send_sample(make_sample(255, 99, 255, 100, 32767, 4095));
    send_sample(make_sample(0, 100, 0, 255, 0, 4096));
    send_sample(make_sample(100, 0, 100, 0, 16384, 4137));
    send_sample(make_sample(100, 0, 100, 0, 16384, 4136));
    for (i = 0; i < 6; i++) begin
      send_sample(make_sample(30, i * 10, 50, i * 5, 200 + i * 3, 1000 + i * 41));
    end
    send_sample(make_sample(30, 50, 50, 20, 210, 1100));
    send_sample(make_sample(30, 50, 50, 20, 210, 1100));
    send_sample(make_sample(0, 1, 128, 128, 1, 1));

    for (p = 0; p < PhaseCount; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: program_deviations('0, '0, '0, '0);
          2: program_deviations(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          default: program_deviations(pick_deviation(32767), pick_deviation(32767),
                                      pick_deviation(32767), pick_deviation(127));
        endcase
      end
      gappy = (p != 1);
      case (p)
        0:       span = 40;
        1:       span = 3;
        2:       span = 500;
        default: span = $urandom_range(0, 300);
      endcase
      // hold the result side off for a long stretch while samples keep coming
      if (p == 3) pressure_req = 1'b1;
      repeat (ItemsPerPhase) send_sample(drift_sample(span));
    end

    settle();
    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    int   r;
    int   n;
    logic hold;
    result_stall  = 1'b0;
    pressure_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (pressure_req && !pressure_done) begin
        hold          = 1'b1;
        n             = PressureCycles;
        pressure_done = 1'b1;
      end else if (!gappy || r < 50) begin
        hold = 1'b0;
        n    = $urandom_range(1, 10);
      end else if (r < 85) begin
        hold = 1'b1;
        n    = $urandom_range(1, 3);
      end else if (r < 96) begin
        hold = 1'b1;
        n    = $urandom_range(4, 12);
      end else begin
        hold = 1'b1;
        n    = $urandom_range(20, 60);
      end
      result_stall <= hold;
      repeat (n) @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/swd_pkg.sv
rtl/swd_front.sv
rtl/swd_lane.sv
rtl/four_lane_swinging_door_compressor.sv
rtl/swd_checker.sv
tb/sv/swd_result_checker.sv
tb/sv/tb.sv
